// ----- rtl/fsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg
// shared types, status codes and the byte-wide crc-16 update for the frame
// sync crc checker
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_BAD_VER  = 3'd2;
    localparam logic [2:0] ST_BAD_CRC  = 3'd3;
    localparam logic [2:0] ST_OVERSIZE = 3'd4;

    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_EXP_VERSION = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;
    localparam logic [3:0] EXP_VERSION_RST = 4'h1;

    localparam logic [7:0]  HDR_BYTES = 8'd8;
    localparam logic [7:0]  CRC_BYTES = 8'd2;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // one result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame_type;
        logic [15:0] source_id;
        logic [7:0]  sequence_res;
        logic [3:0]  fragment_index;
        logic [3:0]  fragment_count;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [7:0]  payload_index;
    } t_result;

    // crc-16/ccitt-false, msb first, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/fsc_frame_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_frame_ctrl
// sync hunt, header capture, length check and running crc; forms the result
// of each accepted byte in the same cycle
// ----------------------------------------------------------------------------
module fsc_frame_ctrl
    import fsc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output t_result    o_result
);

    localparam logic [8:0] MaxTotal = 9'(MAX_FRAME_BYTES);

    logic [7:0]  r_sync_first, r_sync_second;
    logic [3:0]  r_exp_version;

    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_total, n_total;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_low, n_crc_low;
    logic        r_ver_good, n_ver_good;
    logic [3:0]  r_type, n_type;
    logic [15:0] r_source, n_source;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_frag, n_frag;
    logic [7:0]  r_len, n_len;

    logic [15:0] crc_upd;
    logic [8:0]  len_total;
    logic [15:0] rx_crc;
    logic [2:0]  status;
    t_result     res;

    assign crc_upd   = crc16_byte(r_crc, i_rx_byte);
    assign len_total = {1'b0, i_rx_byte} + {1'b0, HDR_BYTES} + {1'b0, CRC_BYTES};
    assign rx_crc    = {i_rx_byte, r_crc_low};

    always_comb begin
        n_pos      = r_pos;
        n_total    = r_total;
        n_crc      = r_crc;
        n_crc_low  = r_crc_low;
        n_ver_good = r_ver_good;
        n_type     = r_type;
        n_source   = r_source;
        n_seq      = r_seq;
        n_frag     = r_frag;
        n_len      = r_len;
        status     = ST_NONE;
        res        = '0;

        priority if (r_pos == 8'd0) begin
            if (i_rx_byte == r_sync_first) begin
                n_crc = crc16_byte(CRC_INIT, i_rx_byte);
                n_pos = 8'd1;
            end
        end else if (r_pos == 8'd1) begin
            priority if (i_rx_byte == r_sync_second) begin
                n_crc = crc_upd;
                n_pos = 8'd2;
            end else if (i_rx_byte == r_sync_first) begin
                n_crc = crc16_byte(CRC_INIT, i_rx_byte);
                n_pos = 8'd1;
            end else begin
                n_pos   = 8'd0;
                n_total = 8'd0;
                n_crc   = CRC_INIT;
            end
        end else if (r_pos < HDR_BYTES) begin
            n_crc = crc_upd;
            n_pos = r_pos + 8'd1;
            unique case (r_pos[2:0])
                3'd2: begin
                    n_ver_good = (i_rx_byte[7:4] == r_exp_version);
                    n_type     = i_rx_byte[3:0];
                end
                3'd3: n_source = {r_source[15:8], i_rx_byte};
                3'd4: n_source = {i_rx_byte, r_source[7:0]};
                3'd5: n_seq    = i_rx_byte;
                3'd6: n_frag   = i_rx_byte;
                3'd7: begin
                    n_len = i_rx_byte;
                    if (len_total > MaxTotal) begin
                        status  = ST_OVERSIZE;
                        n_pos   = 8'd0;
                        n_total = 8'd0;
                        n_crc   = CRC_INIT;
                    end else begin
                        n_total = len_total[7:0];
                    end
                end
                default: ;
            endcase
        end else if (r_total < HDR_BYTES + CRC_BYTES || r_pos >= r_total) begin
            // lost track of the frame, drop the byte
            n_pos   = 8'd0;
            n_total = 8'd0;
            n_crc   = CRC_INIT;
        end else if (r_pos < r_total - CRC_BYTES) begin
            n_crc             = crc_upd;
            n_pos             = r_pos + 8'd1;
            res.payload_byte  = i_rx_byte;
            res.payload_valid = 1'b1;
            res.payload_index = r_pos - HDR_BYTES;
        end else if (r_pos == r_total - CRC_BYTES) begin
            n_crc_low = i_rx_byte;
            n_pos     = r_pos + 8'd1;
        end else begin
            priority if (!r_ver_good) begin
                status = ST_BAD_VER;
            end else if (rx_crc != r_crc) begin
                status = ST_BAD_CRC;
            end else begin
                status = ST_OK;
            end
            n_pos   = 8'd0;
            n_total = 8'd0;
            n_crc   = CRC_INIT;
        end

        res.status = status;
        if (status != ST_NONE) begin
            res.frame_type     = n_type;
            res.source_id      = n_source;
            res.sequence_res   = n_seq;
            res.fragment_index = n_frag[7:4];
            res.fragment_count = n_frag[3:0];
            res.payload_length = n_len;
        end
    end

    assign o_result = res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_exp_version <= EXP_VERSION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                CFG_EXP_VERSION: r_exp_version <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 8'd0;
            r_total    <= 8'd0;
            r_crc      <= CRC_INIT;
            r_ver_good <= 1'b0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_total    <= n_total;
            r_crc      <= n_crc;
            r_ver_good <= n_ver_good;
        end
    end

    // captured header fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_low <= 8'd0;
            r_type    <= 4'd0;
            r_source  <= 16'd0;
            r_seq     <= 8'd0;
            r_frag    <= 8'd0;
            r_len     <= 8'd0;
        end else if (i_accept) begin
            r_crc_low <= n_crc_low;
            r_type    <= n_type;
            r_source  <= n_source;
            r_seq     <= n_seq;
            r_frag    <= n_frag;
            r_len     <= n_len;
        end
    end

endmodule

// ----- rtl/fsc_skid_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_skid_buf
// result register with one skid entry; ready toward the source is registered
// ----------------------------------------------------------------------------
module fsc_skid_buf
    import fsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;
    logic    out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end
        if (!out_free && i_push) begin
            r_skid_data <= i_data;
        end
    end

endmodule

// ----- rtl/frame_sync_crc_checker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_sync_crc_checker_unit
// framed byte receiver: sync hunt, 8-byte header, length check, crc-16 check
// ----------------------------------------------------------------------------
// output: a result is registered in the result register, or in the skid entry
// throughput: one byte per cycle while the skid entry is empty, set by the
//   byte-wide crc update feeding the frame state registers combinationally
// reset: synchronous active-low i_rst_n; block hunts for sync, crc is 0xFFFF,
//   sync bytes and version return to 0xA5, 0x5A and 1, no result pending
module frame_sync_crc_checker_unit
    import fsc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_frame_type,
    output logic [15:0] o_source_id,
    output logic [7:0]  o_sequence_res,
    output logic [3:0]  o_fragment_index,
    output logic [3:0]  o_fragment_count,
    output logic [7:0]  o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_index
);

    logic    rx_accept;
    t_result step_res;
    t_result out_res;

    // every accepted byte yields exactly one result transaction
    assign rx_accept = i_rx_valid && o_rx_ready;

    // frame tracking and per-byte result
    fsc_frame_ctrl #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (step_res)
    );

    // result register plus skid entry so input keeps flowing under stall
    fsc_skid_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rx_accept),
        .i_data  (step_res),
        .o_ready (o_rx_ready),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_data  (out_res)
    );

    assign o_status         = out_res.status;
    assign o_frame_type     = out_res.frame_type;
    assign o_source_id      = out_res.source_id;
    assign o_sequence_res   = out_res.sequence_res;
    assign o_fragment_index = out_res.fragment_index;
    assign o_fragment_count = out_res.fragment_count;
    assign o_payload_length = out_res.payload_length;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_payload_valid  = out_res.payload_valid;
    assign o_payload_index  = out_res.payload_index;

`ifndef SYNTHESIS
    // skid entry only fills behind a held result
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> o_res_valid)
        else $error("input stalled with no result pending");

    // input only stalls after a transaction arrived while output was blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_rx_ready) |-> $past(i_rx_valid && o_res_valid && !i_res_ready))
        else $error("input ready dropped without a blocked output");

    // stall releases only when the held result is taken
    a_release_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rx_ready) |-> $past(o_res_valid && i_res_ready))
        else $error("input ready rose without an output transaction");

    // a payload byte never carries a frame status
    a_payload_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_payload_valid) |-> (o_status == ST_NONE))
        else $error("payload byte reported with a frame status");
`endif

endmodule
